// ===== hdl/xoroshiro1024_state_engine_assert.svh =====
// Assertion macros for the xoroshiro1024 state engine checker
`ifndef XOROSHIRO1024_STATE_ENGINE_ASSERT_SVH
`define XOROSHIRO1024_STATE_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define X1024_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("x1024 assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define X1024_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("x1024 assertion failed");

`endif

// ===== hdl/x1024_pkg.sv =====
// Shared types and constants of the xoroshiro1024 state engine
`default_nettype none

package x1024_pkg;

  localparam int unsigned STATE_WORDS = 16;
  localparam int unsigned IDX_W       = $clog2(STATE_WORDS);
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned BIT_W       = $clog2(WORD_W);

  localparam int unsigned ROT_BACK    = 25;
  localparam int unsigned SHL_BACK    = 27;
  localparam int unsigned ROT_FRONT   = 36;

  typedef logic [IDX_W-1:0]  addr_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BIT_W-1:0]  bit_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } wr_req_t;

  typedef enum logic [2:0] {
    OP_FILL  = 3'd0,
    OP_WRITE = 3'd1,
    OP_SETPOS = 3'd2,
    OP_STEP  = 3'd3,
    OP_JUMP  = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_WRITE,
    S_READ,
    S_READ_W,
    S_STEP_RD,
    S_STEP_CALC,
    S_STEP_WR,
    S_ACC,
    S_WB,
    S_DONE
  } fsm_e;

endpackage

`default_nettype wire

// ===== hdl/xoroshiro1024_state_engine.sv =====
// xoroshiro1024 state engine: state and jump accumulator in memories, sequenced read-modify-write
// From accept to done_o: set position or unused opcode go straight to done; write and read
// make their memory access; step reads, mixes and writes back; fill writes every word; a jump
// word steps per polynomial bit, accumulates per set bit and writes back on the last word, paced
// by the state memory's single write port. One transaction at a time: busy holds through done_o.
// Results show for one cycle, no receiver stall; reset zeroes the state through word flags.
`default_nettype none

module xoroshiro1024_state_engine (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          opcode_i,
  input  wire logic [3:0]          word_index_i,
  input  wire logic [63:0]         data_value_i,
  input  wire logic                jump_last_i,
  output logic                     done_o,
  output logic [63:0]              front_word_o,
  output logic [63:0]              back_word_o,
  output logic [3:0]               current_position_o,
  output logic                     state_nonzero_o
);

  x1024_pkg::fsm_e state_q, state_d;
  x1024_pkg::cnt_t cnt_q, cnt_d;
  x1024_pkg::bit_t bit_q, bit_d;
  x1024_pkg::addr_t pos_q, pos_d;

  logic [2:0]        op_q;
  x1024_pkg::addr_t  idx_q;
  x1024_pkg::word_t  data_q;
  logic              last_q;

  x1024_pkg::word_t  front_q, front_d;
  x1024_pkg::word_t  back_q, back_d;
  x1024_pkg::word_t  mixf_q;

  x1024_pkg::wr_req_t st_wr, acc_wr;
  x1024_pkg::addr_t   st_ra, st_rb, acc_ra;
  x1024_pkg::word_t   st_rd_a, st_rd_b, acc_rd;
  logic               acc_clr;
  logic               st_nz;
  logic               acc_nz_unused;
  x1024_pkg::word_t   acc_rd_b_unused;

  logic               accept;
  x1024_pkg::addr_t   ahead;
  x1024_pkg::addr_t   cnt_idx;
  x1024_pkg::addr_t   prev_idx;
  x1024_pkg::bit_t    bit_nxt;
  x1024_pkg::word_t   s0, s15, mix_b, mix_f;

  assign accept   = start && !busy;
  assign ahead    = pos_q + x1024_pkg::addr_t'(1);
  assign cnt_idx  = cnt_q[x1024_pkg::IDX_W-1:0];
  assign prev_idx = cnt_idx - x1024_pkg::addr_t'(1);
  assign bit_nxt  = bit_q + x1024_pkg::bit_t'(1);

  // generator mix: st_rd_a holds the word ahead, st_rd_b the word behind
  always_comb begin
    s0    = st_rd_a;
    s15   = st_rd_b ^ s0;
    mix_b = ((s0 << x1024_pkg::ROT_BACK) | (s0 >> (x1024_pkg::WORD_W - x1024_pkg::ROT_BACK)))
            ^ s15 ^ (s15 << x1024_pkg::SHL_BACK);
    mix_f = (s15 << x1024_pkg::ROT_FRONT) | (s15 >> (x1024_pkg::WORD_W - x1024_pkg::ROT_FRONT));
  end

  x1024_store u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (st_wr),
    .clr_i     (1'b0),
    .raddr_a_i (st_ra),
    .raddr_b_i (st_rb),
    .rdata_a_o (st_rd_a),
    .rdata_b_o (st_rd_b),
    .nonzero_o (st_nz)
  );

  x1024_store u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (acc_wr),
    .clr_i     (acc_clr),
    .raddr_a_i (acc_ra),
    .raddr_b_i (acc_ra),
    .rdata_a_o (acc_rd),
    .rdata_b_o (acc_rd_b_unused),
    .nonzero_o (acc_nz_unused)
  );

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    pos_d   = pos_q;
    case (state_q)
      x1024_pkg::S_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          bit_d = '0;
          case (opcode_i)
            x1024_pkg::OP_FILL:   state_d = x1024_pkg::S_FILL;
            x1024_pkg::OP_WRITE:  state_d = x1024_pkg::S_WRITE;
            x1024_pkg::OP_SETPOS: begin
              pos_d   = word_index_i;
              state_d = x1024_pkg::S_DONE;
            end
            x1024_pkg::OP_STEP:   state_d = x1024_pkg::S_STEP_RD;
            x1024_pkg::OP_JUMP:   state_d = data_value_i[0] ? x1024_pkg::S_ACC
                                                            : x1024_pkg::S_STEP_RD;
            x1024_pkg::OP_READ:   state_d = x1024_pkg::S_READ;
            default:              state_d = x1024_pkg::S_DONE;
          endcase
        end
      end
      x1024_pkg::S_FILL: begin
        cnt_d = cnt_q + x1024_pkg::cnt_t'(1);
        if (cnt_idx == x1024_pkg::addr_t'(x1024_pkg::STATE_WORDS - 1)) begin
          state_d = x1024_pkg::S_DONE;
        end
      end
      x1024_pkg::S_WRITE:     state_d = x1024_pkg::S_DONE;
      x1024_pkg::S_READ:      state_d = x1024_pkg::S_READ_W;
      x1024_pkg::S_READ_W:    state_d = x1024_pkg::S_DONE;
      x1024_pkg::S_STEP_RD:   state_d = x1024_pkg::S_STEP_CALC;
      x1024_pkg::S_STEP_CALC: begin
        pos_d   = ahead;
        state_d = x1024_pkg::S_STEP_WR;
      end
      x1024_pkg::S_STEP_WR: begin
        cnt_d = '0;
        if (op_q != x1024_pkg::OP_JUMP) begin
          state_d = x1024_pkg::S_DONE;
        end else if (bit_q == x1024_pkg::bit_t'(x1024_pkg::WORD_W - 1)) begin
          state_d = last_q ? x1024_pkg::S_WB : x1024_pkg::S_DONE;
        end else begin
          bit_d   = bit_nxt;
          state_d = data_q[bit_nxt] ? x1024_pkg::S_ACC : x1024_pkg::S_STEP_RD;
        end
      end
      x1024_pkg::S_ACC: begin
        cnt_d = cnt_q + x1024_pkg::cnt_t'(1);
        if (cnt_q == x1024_pkg::cnt_t'(x1024_pkg::STATE_WORDS)) begin
          cnt_d   = '0;
          state_d = x1024_pkg::S_STEP_RD;
        end
      end
      x1024_pkg::S_WB: begin
        cnt_d = cnt_q + x1024_pkg::cnt_t'(1);
        if (cnt_q == x1024_pkg::cnt_t'(x1024_pkg::STATE_WORDS)) begin
          cnt_d   = '0;
          state_d = x1024_pkg::S_DONE;
        end
      end
      x1024_pkg::S_DONE:      state_d = x1024_pkg::S_IDLE;
      default:                state_d = x1024_pkg::S_IDLE;
    endcase
  end

  // memory accesses and result capture
  always_comb begin
    st_wr   = '0;
    acc_wr  = '0;
    st_ra   = pos_q;
    st_rb   = pos_q;
    acc_ra  = cnt_idx;
    acc_clr = 1'b0;
    front_d = front_q;
    back_d  = back_q;
    case (state_q)
      x1024_pkg::S_IDLE: begin
        if (accept) begin
          front_d = '0;
          back_d  = '0;
        end
      end
      x1024_pkg::S_FILL: begin
        st_wr.en   = 1'b1;
        st_wr.addr = cnt_idx;
        st_wr.data = data_q;
      end
      x1024_pkg::S_WRITE: begin
        st_wr.en   = 1'b1;
        st_wr.addr = idx_q;
        st_wr.data = data_q;
      end
      x1024_pkg::S_READ: begin
        st_ra = idx_q;
      end
      x1024_pkg::S_READ_W: begin
        front_d = st_rd_a;
      end
      x1024_pkg::S_STEP_RD: begin
        st_ra = ahead;
        st_rb = pos_q;
      end
      x1024_pkg::S_STEP_CALC: begin
        st_wr.en   = 1'b1;
        st_wr.addr = pos_q;
        st_wr.data = mix_b;
        if (op_q == x1024_pkg::OP_STEP) begin
          front_d = mix_f;
          back_d  = mix_b;
        end
      end
      x1024_pkg::S_STEP_WR: begin
        st_wr.en   = 1'b1;
        st_wr.addr = pos_q;
        st_wr.data = mixf_q;
      end
      x1024_pkg::S_ACC: begin
        st_ra = pos_q + cnt_idx;
        if (cnt_q != '0) begin
          acc_wr.en   = 1'b1;
          acc_wr.addr = prev_idx;
          acc_wr.data = acc_rd ^ st_rd_a;
        end
      end
      x1024_pkg::S_WB: begin
        if (cnt_q != '0) begin
          st_wr.en   = 1'b1;
          st_wr.addr = pos_q + prev_idx;
          st_wr.data = acc_rd;
        end
        if (cnt_q == x1024_pkg::cnt_t'(x1024_pkg::STATE_WORDS)) begin
          acc_clr = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= x1024_pkg::S_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      idx_q  <= word_index_i;
      data_q <= data_value_i;
      last_q <= jump_last_i;
    end
    if (state_q == x1024_pkg::S_STEP_CALC) begin
      mixf_q <= mix_f;
    end
    front_q <= front_d;
    back_q  <= back_d;
  end

  assign busy               = (state_q != x1024_pkg::S_IDLE);
  assign done_o             = (state_q == x1024_pkg::S_DONE);
  assign front_word_o       = front_q;
  assign back_word_o        = back_q;
  assign current_position_o = pos_q;
  assign state_nonzero_o    = st_nz;

endmodule

`default_nettype wire

// ===== hdl/x1024_store.sv =====
// Sixteen-word store with one write port, two registered read ports and per-word zero tracking
`default_nettype none

module x1024_store (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire x1024_pkg::wr_req_t wr_i,
  input  wire logic               clr_i,
  input  wire x1024_pkg::addr_t   raddr_a_i,
  input  wire x1024_pkg::addr_t   raddr_b_i,
  output x1024_pkg::word_t        rdata_a_o,
  output x1024_pkg::word_t        rdata_b_o,
  output logic                    nonzero_o
);

  x1024_pkg::word_t mem_q [x1024_pkg::STATE_WORDS];
  x1024_pkg::word_t rd_a_q;
  x1024_pkg::word_t rd_b_q;
  logic [x1024_pkg::STATE_WORDS-1:0] nz_q;
  logic rd_a_nz_q;
  logic rd_b_nz_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  // a word whose flag is clear reads as zero, so reset needs no sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q      <= '0;
      rd_a_nz_q <= 1'b0;
      rd_b_nz_q <= 1'b0;
    end else begin
      rd_a_nz_q <= nz_q[raddr_a_i];
      rd_b_nz_q <= nz_q[raddr_b_i];
      if (clr_i) begin
        nz_q <= '0;
      end else if (wr_i.en) begin
        nz_q[wr_i.addr] <= (wr_i.data != '0);
      end
    end
  end

  assign rdata_a_o = rd_a_nz_q ? rd_a_q : '0;
  assign rdata_b_o = rd_b_nz_q ? rd_b_q : '0;
  assign nonzero_o = |nz_q;

endmodule

`default_nettype wire

// ===== hdl/x1024_checker.sv =====
// Port-level checker for the xoroshiro1024 state engine, with its bind
`default_nettype none

`include "xoroshiro1024_state_engine_assert.svh"

module x1024_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [2:0]  opcode_i,
  input wire logic [3:0]  word_index_i,
  input wire logic [63:0] data_value_i,
  input wire logic        jump_last_i,
  input wire logic        done_o,
  input wire logic [63:0] front_word_o,
  input wire logic [63:0] back_word_o,
  input wire logic [3:0]  current_position_o,
  input wire logic        state_nonzero_o
);

  logic setpos_go;

  assign setpos_go = start && !busy && (opcode_i == x1024_pkg::OP_SETPOS);

  `X1024_ASSERT_NOW(a_done_while_busy, done_o, busy)
  `X1024_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
  `X1024_ASSERT_NEXT(a_done_single, done_o, !done_o && !busy)
  `X1024_ASSERT_NEXT(a_setpos_pos, setpos_go, current_position_o == $past(word_index_i))
  `X1024_ASSERT_NEXT(a_setpos_done, setpos_go, done_o && (front_word_o == 64'd0))

endmodule

bind xoroshiro1024_state_engine x1024_checker u_x1024_checker (.*);

`default_nettype wire

// ===== bench/xoroshiro1024_state_engine_checker.sv =====
// Predicts each xoroshiro1024 engine transaction and compares every result with it
module xoroshiro1024_state_engine_checker
  import x1024_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  opcode_i,
  input  addr_t       word_index_i,
  input  word_t       data_value_i,
  input  logic        jump_last_i,
  input  logic        done_i,
  input  word_t       front_word_i,
  input  word_t       back_word_i,
  input  addr_t       current_position_i,
  input  logic        state_nonzero_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    word_t front;
    word_t back;
    addr_t pos;
    logic  nz;
  } outcome_t;

  word_t    gen_words [STATE_WORDS];
  word_t    jump_acc [STATE_WORDS];
  addr_t    gen_pos;
  outcome_t outcome_q [$];

  function automatic word_t rotl(word_t v, int unsigned k);
    return (v << k) | (v >> (WORD_W - k));
  endfunction

  task automatic advance_state(output word_t fw, output word_t bw);
    addr_t behind;
    addr_t ahead;
    word_t s0;
    word_t s15;
    behind = gen_pos;
    ahead  = gen_pos + 1'b1;
    s0  = gen_words[ahead];
    s15 = gen_words[behind] ^ s0;
    bw  = rotl(s0, ROT_BACK) ^ s15 ^ (s15 << SHL_BACK);
    fw  = rotl(s15, ROT_FRONT);
    gen_words[behind] = bw;
    gen_words[ahead]  = fw;
    gen_pos = ahead;
  endtask

  task automatic predict_outcome(input logic [2:0] op, input addr_t idx, input word_t data,
                                 input logic last);
    outcome_t o;
    word_t    fw;
    word_t    bw;
    word_t    any_bits;
    int       b;
    o.front = '0;
    o.back  = '0;
    case (op)
      OP_FILL: begin
        foreach (gen_words[i]) gen_words[i] = data;
      end
      OP_WRITE: gen_words[idx] = data;
      OP_SETPOS: gen_pos = idx;
      OP_STEP: begin
        advance_state(fw, bw);
        o.front = fw;
        o.back  = bw;
      end
      OP_JUMP: begin
        for (b = 0; b < WORD_W; b++) begin
          if (data[b]) begin
            foreach (jump_acc[j]) jump_acc[j] ^= gen_words[addr_t'(gen_pos + j)];
          end
          advance_state(fw, bw);
        end
        if (last) begin
          foreach (jump_acc[j]) begin
            gen_words[addr_t'(gen_pos + j)] = jump_acc[j];
            jump_acc[j] = '0;
          end
        end
      end
      OP_READ: o.front = gen_words[idx];
      default: ;
    endcase
    any_bits = '0;
    foreach (gen_words[i]) any_bits |= gen_words[i];
    o.pos = gen_pos;
    o.nz  = |any_bits;
    outcome_q.push_back(o);
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (!rst_ni) begin
      foreach (gen_words[i]) begin
        gen_words[i] = '0;
        jump_acc[i]  = '0;
      end
      gen_pos = '0;
      outcome_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          $error("result with no transaction outstanding");
          mismatch_count_o++;
        end else begin
          want = outcome_q.pop_front();
          if (front_word_i !== want.front) begin
            $error("front_word: expected %h, actual %h", want.front, front_word_i);
            mismatch_count_o++;
          end
          if (back_word_i !== want.back) begin
            $error("back_word: expected %h, actual %h", want.back, back_word_i);
            mismatch_count_o++;
          end
          if (current_position_i !== want.pos) begin
            $error("current_position: expected %0d, actual %0d", want.pos,
                   current_position_i);
            mismatch_count_o++;
          end
          if (state_nonzero_i !== want.nz) begin
            $error("state_nonzero: expected %b, actual %b", want.nz, state_nonzero_i);
            mismatch_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_outcome(opcode_i, word_index_i, data_value_i, jump_last_i);
      end
    end
    outstanding_o = outcome_q.size();
  end

endmodule

// ===== bench/xoroshiro1024_state_engine_tb.sv =====
// Top of the xoroshiro1024 state engine bench: clock, reset, transaction stimulus, verdict
module xoroshiro1024_state_engine_tb;
  import x1024_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  OP_RSVD_6  = 3'd6;
  localparam logic [2:0]  OP_RSVD_7  = 3'd7;
  localparam int unsigned RAND_ITEMS = 500;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  opcode_i;
  addr_t       word_index_i;
  word_t       data_value_i;
  logic        jump_last_i;
  logic        done_o;
  word_t       front_word_o;
  word_t       back_word_o;
  addr_t       current_position_o;
  logic        state_nonzero_o;
  int unsigned mismatch_count;
  int unsigned outstanding;
  bit          no_idle;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  xoroshiro1024_state_engine i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .word_index_i       (word_index_i),
    .data_value_i       (data_value_i),
    .jump_last_i        (jump_last_i),
    .done_o             (done_o),
    .front_word_o       (front_word_o),
    .back_word_o        (back_word_o),
    .current_position_o (current_position_o),
    .state_nonzero_o    (state_nonzero_o)
  );

  xoroshiro1024_state_engine_checker i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .opcode_i           (opcode_i),
    .word_index_i       (word_index_i),
    .data_value_i       (data_value_i),
    .jump_last_i        (jump_last_i),
    .done_i             (done_o),
    .front_word_i       (front_word_o),
    .back_word_i        (back_word_o),
    .current_position_i (current_position_o),
    .state_nonzero_i    (state_nonzero_o),
    .mismatch_count_o   (mismatch_count),
    .outstanding_o      (outstanding)
  );

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t data_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return rand_word();
    endcase
  endfunction

  // jump polynomial words: sparse ones keep the number of accumulate passes low
  function automatic word_t poly_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return word_t'($urandom_range(1, 255)) << $urandom_range(0, 56);
      default: return rand_word();
    endcase
  endfunction

  task automatic issue(input logic [2:0] op, input addr_t idx, input word_t data,
                       input logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    word_index_i <= idx;
    data_value_i <= data;
    jump_last_i  <= last;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    int unsigned counted;
    int unsigned roll;
    int unsigned jump_left;
    logic        close_run;
    logic [2:0]  op;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    opcode_i     <= OP_FILL;
    word_index_i <= '0;
    data_value_i <= '0;
    jump_last_i  <= 1'b0;
    no_idle      = 1'b0;
    counted      = 0;
    jump_left    = 0;
    close_run    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero state, extremes, unused opcodes, short jump, ops inside a jump
    issue(OP_STEP, 4'd0, '0, 1'b0);
    issue(OP_JUMP, 4'd15, '1, 1'b1);
    issue(OP_RSVD_6, 4'd15, '1, 1'b1);
    issue(OP_FILL, 4'd0, '1, 1'b0);
    issue(OP_READ, 4'd15, '0, 1'b1);
    issue(OP_WRITE, 4'd0, '0, 1'b0);
    issue(OP_WRITE, 4'd15, 64'h8000_0000_0000_0001, 1'b1);
    issue(OP_READ, 4'd0, '1, 1'b0);
    issue(OP_SETPOS, 4'd15, '0, 1'b0);
    issue(OP_STEP, 4'd3, rand_word(), 1'b1);
    issue(OP_JUMP, 4'd0, 64'h8000_0000_0000_0001, 1'b0);
    issue(OP_WRITE, 4'd7, rand_word(), 1'b0);
    issue(OP_STEP, 4'd0, '0, 1'b0);
    issue(OP_SETPOS, 4'd0, '1, 1'b0);
    issue(OP_FILL, 4'd5, rand_word(), 1'b0);
    issue(OP_JUMP, 4'd0, '0, 1'b0);
    issue(OP_JUMP, 4'd0, rand_word(), 1'b1);
    issue(OP_RSVD_7, 4'd0, '0, 1'b0);
    issue(OP_FILL, 4'd0, '0, 1'b0);
    issue(OP_JUMP, 4'd0, rand_word(), 1'b1);
    issue(OP_STEP, 4'd0, '0, 1'b0);
    issue(OP_WRITE, 4'd9, rand_word(), 1'b0);
    issue(OP_READ, 4'd9, '0, 1'b0);

    // random: mostly jump runs with other ops mixed in, plus stray jump words
    while (counted < RAND_ITEMS) begin
      if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
      if (jump_left != 0 && $urandom_range(0, 7) != 0) begin
        issue(OP_JUMP, addr_t'($urandom_range(0, 15)), poly_word(),
              (jump_left == 1) && close_run);
        jump_left--;
        counted++;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          op = OP_STEP;
        end else if (roll < 45) begin
          op = OP_WRITE;
        end else if (roll < 55) begin
          op = OP_READ;
        end else if (roll < 63) begin
          op = OP_SETPOS;
        end else if (roll < 68) begin
          op = OP_FILL;
        end else if (roll < 73) begin
          op = ($urandom_range(0, 1) != 0) ? OP_RSVD_7 : OP_RSVD_6;
        end else begin
          op = OP_JUMP;
        end
        if (op == OP_JUMP && jump_left == 0 && roll >= 80) begin
          jump_left = ($urandom_range(0, 9) < 7) ? 16 : $urandom_range(1, 15);
          close_run = ($urandom_range(0, 9) != 0);
        end else begin
          issue(op, addr_t'($urandom_range(0, 15)),
                (op == OP_JUMP) ? poly_word() : data_word(), 1'($urandom_range(0, 1)));
          if (op < OP_RSVD_6) counted++;
        end
      end
    end
    start <= 1'b0;

    // the checker registers the last transaction at its accept edge
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (32) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("xoroshiro1024_state_engine_tb: PASS");
    end else begin
      $display("xoroshiro1024_state_engine_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("xoroshiro1024_state_engine_tb: FAIL");
    $finish;
  end

endmodule
